[sv/cfbp_pkg.sv]
// Shared types, constants and codes for the checked fixed block pool.
`timescale 1ns / 1ps

package cfbp_pkg;

  // Pool geometry; ALIGN must be a power of two
  localparam int NUM_SLOTS = 64;
  localparam int ALIGN     = 4;

  localparam int IDX_W     = $clog2(NUM_SLOTS);
  localparam int CNT_W     = 7;    // free_blocks / block_count field width
  localparam int ADDR_W    = 32;
  localparam int BYTES_W   = 16;
  localparam int BASE_W    = ADDR_W + 1;   // aligned base may carry past 32 bits
  localparam int STEP_W    = BYTES_W + 1;
  localparam int ACC_W     = ADDR_W + 2;   // region end sums, no wrap
  localparam int MIN_BLOCK_BYTES = 4;

  localparam int IN_W      = 40;
  localparam int OUT_W     = 48;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [1:0] {
    FN_ALLOC = 2'd0,
    FN_FREE  = 2'd1,
    FN_INIT  = 2'd2
  } func_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_EMPTY   = 3'd1,
    ST_BADADDR = 3'd2,
    ST_DUP     = 3'd3,
    ST_NOSLOT  = 3'd4,
    ST_FULL    = 3'd5,
    ST_PARAM   = 3'd6
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REGION_START = 2'd0,
    CFG_BLOCK_BYTES  = 2'd1,
    CFG_BLOCK_COUNT  = 2'd2
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLR,
    S_TRIM_END,
    S_TRIM_WRAP,
    S_FILL,
    S_ALLOC_SCAN,
    S_ALLOC_RD,
    S_FREE_SCAN,
    S_FREE_WR,
    S_DONE
  } state_t;

  // Slot store access: one address for read, write and valid update
  typedef struct packed {
    logic              mem_we;
    logic              vld_we;
    logic              vld_val;
    logic [IDX_W-1:0]  addr;
    logic [ADDR_W-1:0] wdata;
  } slot_cmd_t;

  typedef struct packed {
    logic [ADDR_W-1:0] rd_data;  // registered read of last cycle's address
    logic              rd_vld;   // valid bit sampled with rd_data
    logic              at_vld;   // valid bit at the current address
  } slot_rsp_t;

endpackage

[sv/cfbp_slot_store.sv]
// Slot table: single-port address RAM with a valid bit per slot.
`timescale 1ns / 1ps

module cfbp_slot_store (
  input  logic                clk,
  input  logic                rst_n,
  input  cfbp_pkg::slot_cmd_t cmd,
  output cfbp_pkg::slot_rsp_t rsp
);

  logic [cfbp_pkg::ADDR_W-1:0] mem [cfbp_pkg::NUM_SLOTS];
  logic [cfbp_pkg::NUM_SLOTS-1:0] vld_r;
  logic [cfbp_pkg::ADDR_W-1:0] rd_data_r;
  logic                        rd_vld_r;

  always_ff @(posedge clk) begin
    if (cmd.mem_we) begin
      mem[cmd.addr] <= cmd.wdata;
    end
    rd_data_r <= mem[cmd.addr];
  end

  // An empty slot is marked by its cleared valid bit; its stored address is left as it was
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= vld_r[cmd.addr];
      if (cmd.vld_we) begin
        vld_r[cmd.addr] <= cmd.vld_val;
      end
    end
  end

  assign rsp.rd_data = rd_data_r;
  assign rsp.rd_vld  = rd_vld_r;
  assign rsp.at_vld  = vld_r[cmd.addr];

endmodule

[sv/checked_fixed_block_pool_unit.sv]
// Top level of the checked fixed block pool: sequencer, pool state and stream ports.
// Operation: alloc scans from slot 0 to the first occupied slot, free scans the active
// slots, init clears, trims and fills the block_count slots; rejected words go to the result.
// Throughput: one word at a time, ready again in the cycle the result is registered, which
// waits while a previous result is held by out_tready; the scan checks one slot per cycle.
// Reset: synchronous active-low rst_n clears all slots, the counters and the ready flag.
`timescale 1ns / 1ps

module checked_fixed_block_pool_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  // in_tdata: func[1:0], addr[33:2], zero [39:34]
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [cfbp_pkg::IN_W-1:0]       in_tdata,
  // out_tdata: status[2:0], block_addr[34:3], free_blocks[41:35], zero [47:42]
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [cfbp_pkg::OUT_W-1:0]      out_tdata,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [cfbp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cfbp_pkg::ADDR_W-1:0]     cfg_data
);

  localparam logic [cfbp_pkg::BASE_W-1:0] BASE_MASK = ~cfbp_pkg::BASE_W'(cfbp_pkg::ALIGN - 1);
  localparam logic [cfbp_pkg::STEP_W-1:0] STEP_MASK = ~cfbp_pkg::STEP_W'(cfbp_pkg::ALIGN - 1);

  // configuration
  logic [cfbp_pkg::ADDR_W-1:0]  rs_r;
  logic [cfbp_pkg::BYTES_W-1:0] bb_r;
  logic [cfbp_pkg::CNT_W-1:0]   bc_r;

  // sequencer and pool state
  cfbp_pkg::state_t             state_r, state_nxt;
  logic                         ready_r, ready_nxt;
  logic [cfbp_pkg::CNT_W-1:0]   free_r, free_nxt;
  logic [cfbp_pkg::CNT_W-1:0]   active_r, active_nxt;
  logic [cfbp_pkg::ADDR_W-1:0]  base_r, base_nxt;
  logic [cfbp_pkg::ADDR_W-1:0]  last_r, last_nxt;
  logic [cfbp_pkg::STEP_W-1:0]  step_r, step_nxt;
  logic [cfbp_pkg::BASE_W-1:0]  abase_r, abase_nxt;
  logic [cfbp_pkg::ACC_W-1:0]   acc_o_r, acc_o_nxt;
  logic [cfbp_pkg::ACC_W-1:0]   acc_a_r, acc_a_nxt;
  logic [cfbp_pkg::CNT_W-1:0]   n_r, n_nxt;
  logic [cfbp_pkg::CNT_W-1:0]   scan_r, scan_nxt;
  logic [cfbp_pkg::IDX_W-1:0]   hole_r, hole_nxt;
  logic                         have_hole_r, have_hole_nxt;
  logic                         pend_r, pend_nxt;
  logic [cfbp_pkg::ADDR_W-1:0]  addr_r, addr_nxt;
  cfbp_pkg::status_t            res_st_r, res_st_nxt;
  logic [cfbp_pkg::ADDR_W-1:0]  res_addr_r, res_addr_nxt;

  // output register
  logic                         out_valid_r, out_valid_nxt;
  cfbp_pkg::status_t            out_st_r, out_st_nxt;
  logic [cfbp_pkg::ADDR_W-1:0]  out_addr_r, out_addr_nxt;
  logic [cfbp_pkg::CNT_W-1:0]   out_free_r, out_free_nxt;

  cfbp_pkg::slot_cmd_t          cmd;
  cfbp_pkg::slot_rsp_t          rsp;

  cfbp_pkg::func_t              in_func;
  logic [cfbp_pkg::ADDR_W-1:0]  in_addr;
  logic                         in_acc;
  logic [cfbp_pkg::BASE_W-1:0]  base_calc;
  logic [cfbp_pkg::STEP_W-1:0]  step_calc;
  logic                         bad_param;
  logic [cfbp_pkg::ACC_W-1:0]   acc_less;
  logic                         issuing;
  logic                         dup_hit;

  cfbp_slot_store u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .rsp   (rsp)
  );

  assign in_tready = (state_r == cfbp_pkg::S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign in_func   = cfbp_pkg::func_t'(in_tdata[1:0]);
  assign in_addr   = in_tdata[cfbp_pkg::ADDR_W+1:2];
  assign cfg_ready = 1'b1;

  assign base_calc = ({1'b0, rs_r} + cfbp_pkg::BASE_W'(cfbp_pkg::ALIGN - 1)) & BASE_MASK;
  assign step_calc = ({1'b0, bb_r} + cfbp_pkg::STEP_W'(cfbp_pkg::ALIGN - 1)) & STEP_MASK;
  assign bad_param = (rs_r == '0) || (bc_r < cfbp_pkg::CNT_W'(2))
                  || (bc_r > cfbp_pkg::CNT_W'(cfbp_pkg::NUM_SLOTS))
                  || (bb_r < cfbp_pkg::BYTES_W'(cfbp_pkg::MIN_BLOCK_BYTES));
  assign acc_less  = acc_a_r - cfbp_pkg::ACC_W'(step_r);
  assign issuing   = (scan_r < active_r);
  assign dup_hit   = pend_r && rsp.rd_vld && (rsp.rd_data == addr_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rs_r <= '0;
      bb_r <= cfbp_pkg::BYTES_W'(4);
      bc_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfbp_pkg::cfg_idx_t'(cfg_index))
        cfbp_pkg::CFG_REGION_START: rs_r <= cfg_data;
        cfbp_pkg::CFG_BLOCK_BYTES:  bb_r <= cfg_data[cfbp_pkg::BYTES_W-1:0];
        cfbp_pkg::CFG_BLOCK_COUNT:  bc_r <= cfg_data[cfbp_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cfbp_pkg::S_IDLE;
      ready_r     <= 1'b0;
      free_r      <= '0;
      active_r    <= '0;
      base_r      <= '0;
      last_r      <= '0;
      step_r      <= '0;
      pend_r      <= 1'b0;
      have_hole_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ready_r     <= ready_nxt;
      free_r      <= free_nxt;
      active_r    <= active_nxt;
      base_r      <= base_nxt;
      last_r      <= last_nxt;
      step_r      <= step_nxt;
      pend_r      <= pend_nxt;
      have_hole_r <= have_hole_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    abase_r    <= abase_nxt;
    acc_o_r    <= acc_o_nxt;
    acc_a_r    <= acc_a_nxt;
    n_r        <= n_nxt;
    scan_r     <= scan_nxt;
    hole_r     <= hole_nxt;
    addr_r     <= addr_nxt;
    res_st_r   <= res_st_nxt;
    res_addr_r <= res_addr_nxt;
    out_st_r   <= out_st_nxt;
    out_addr_r <= out_addr_nxt;
    out_free_r <= out_free_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    ready_nxt     = ready_r;
    free_nxt      = free_r;
    active_nxt    = active_r;
    base_nxt      = base_r;
    last_nxt      = last_r;
    step_nxt      = step_r;
    abase_nxt     = abase_r;
    acc_o_nxt     = acc_o_r;
    acc_a_nxt     = acc_a_r;
    n_nxt         = n_r;
    scan_nxt      = scan_r;
    hole_nxt      = hole_r;
    have_hole_nxt = have_hole_r;
    pend_nxt      = 1'b0;
    addr_nxt      = addr_r;
    res_st_nxt    = res_st_r;
    res_addr_nxt  = res_addr_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_st_nxt    = out_st_r;
    out_addr_nxt  = out_addr_r;
    out_free_nxt  = out_free_r;

    cmd.mem_we  = 1'b0;
    cmd.vld_we  = 1'b0;
    cmd.vld_val = 1'b0;
    cmd.addr    = scan_r[cfbp_pkg::IDX_W-1:0];
    cmd.wdata   = addr_r;

    unique case (state_r)
      cfbp_pkg::S_IDLE: begin
        if (in_acc) begin
          res_addr_nxt = '0;
          res_st_nxt   = cfbp_pkg::ST_PARAM;
          state_nxt    = cfbp_pkg::S_DONE;
          scan_nxt     = '0;
          addr_nxt     = in_addr;
          have_hole_nxt = 1'b0;
          unique case (in_func)
            cfbp_pkg::FN_ALLOC: begin
              if (ready_r && free_r == '0) begin
                res_st_nxt = cfbp_pkg::ST_EMPTY;
              end else if (ready_r) begin
                state_nxt = cfbp_pkg::S_ALLOC_SCAN;
              end
            end
            cfbp_pkg::FN_FREE: begin
              priority if (in_addr == '0 || !ready_r) begin
                res_st_nxt = cfbp_pkg::ST_PARAM;
              end else if (free_r >= active_r) begin
                res_st_nxt = cfbp_pkg::ST_FULL;
              end else if (in_addr < base_r || in_addr > last_r) begin
                res_st_nxt = cfbp_pkg::ST_BADADDR;
              end else begin
                state_nxt = cfbp_pkg::S_FREE_SCAN;
              end
            end
            cfbp_pkg::FN_INIT: begin
              priority if (ready_r) begin
                res_st_nxt = cfbp_pkg::ST_PARAM;
              end else if (bad_param) begin
                free_nxt   = '0;
                active_nxt = '0;
                ready_nxt  = 1'b0;
              end else begin
                abase_nxt = base_calc;
                step_nxt  = step_calc;
                acc_o_nxt = cfbp_pkg::ACC_W'(rs_r);
                acc_a_nxt = cfbp_pkg::ACC_W'(base_calc);
                n_nxt     = bc_r;
                state_nxt = cfbp_pkg::S_CLR;
              end
            end
            default: ;
          endcase
        end
      end

      // Clear the requested slots and build both region ends, one block a cycle
      cfbp_pkg::S_CLR: begin
        if (scan_r == n_r) begin
          state_nxt = cfbp_pkg::S_TRIM_END;
        end else begin
          cmd.vld_we = 1'b1;
          acc_o_nxt  = acc_o_r + cfbp_pkg::ACC_W'(bb_r);
          acc_a_nxt  = acc_a_r + cfbp_pkg::ACC_W'(step_r);
          scan_nxt   = scan_r + 1'b1;
        end
      end

      // Drop blocks whose aligned end passes the original end
      cfbp_pkg::S_TRIM_END: begin
        if (n_r != '0 && acc_a_r > acc_o_r) begin
          acc_a_nxt = acc_less;
          n_nxt     = n_r - 1'b1;
        end else begin
          state_nxt = cfbp_pkg::S_TRIM_WRAP;
        end
      end

      // Drop blocks whose start does not fit in 32 bits; fail the init if fewer than two remain
      cfbp_pkg::S_TRIM_WRAP: begin
        if (n_r != '0 && acc_less[cfbp_pkg::ACC_W-1:cfbp_pkg::ADDR_W] != '0) begin
          acc_a_nxt = acc_less;
          n_nxt     = n_r - 1'b1;
        end else if (n_r < cfbp_pkg::CNT_W'(2)) begin
          free_nxt   = '0;
          active_nxt = '0;
          ready_nxt  = 1'b0;
          res_st_nxt = cfbp_pkg::ST_PARAM;
          state_nxt  = cfbp_pkg::S_DONE;
        end else begin
          acc_o_nxt = cfbp_pkg::ACC_W'(abase_r);
          scan_nxt  = '0;
          state_nxt = cfbp_pkg::S_FILL;
        end
      end

      cfbp_pkg::S_FILL: begin
        if (scan_r == n_r) begin
          base_nxt   = abase_r[cfbp_pkg::ADDR_W-1:0];
          active_nxt = n_r;
          free_nxt   = n_r;
          ready_nxt  = 1'b1;
          res_st_nxt = cfbp_pkg::ST_OK;
          state_nxt  = cfbp_pkg::S_DONE;
        end else begin
          cmd.mem_we  = 1'b1;
          cmd.vld_we  = 1'b1;
          cmd.vld_val = 1'b1;
          cmd.wdata   = acc_o_r[cfbp_pkg::ADDR_W-1:0];
          last_nxt    = acc_o_r[cfbp_pkg::ADDR_W-1:0];
          acc_o_nxt   = acc_o_r + cfbp_pkg::ACC_W'(step_r);
          scan_nxt    = scan_r + 1'b1;
        end
      end

      cfbp_pkg::S_ALLOC_SCAN: begin
        if (!issuing) begin
          res_st_nxt = cfbp_pkg::ST_EMPTY;
          state_nxt  = cfbp_pkg::S_DONE;
        end else if (rsp.at_vld) begin
          state_nxt = cfbp_pkg::S_ALLOC_RD;
        end else begin
          scan_nxt = scan_r + 1'b1;
        end
      end

      // Read data for the found slot lands now; empty the slot
      cfbp_pkg::S_ALLOC_RD: begin
        cmd.vld_we   = 1'b1;
        res_addr_nxt = rsp.rd_data;
        free_nxt     = free_r - 1'b1;
        res_st_nxt   = cfbp_pkg::ST_OK;
        state_nxt    = cfbp_pkg::S_DONE;
      end

      // Issue one slot a cycle, compare the slot read the cycle before, note the first empty slot
      cfbp_pkg::S_FREE_SCAN: begin
        if (dup_hit) begin
          res_st_nxt = cfbp_pkg::ST_DUP;
          state_nxt  = cfbp_pkg::S_DONE;
        end else if (issuing) begin
          pend_nxt = 1'b1;
          scan_nxt = scan_r + 1'b1;
          if (!rsp.at_vld && !have_hole_r) begin
            have_hole_nxt = 1'b1;
            hole_nxt      = scan_r[cfbp_pkg::IDX_W-1:0];
          end
        end else if (have_hole_r) begin
          state_nxt = cfbp_pkg::S_FREE_WR;
        end else begin
          res_st_nxt = cfbp_pkg::ST_NOSLOT;
          state_nxt  = cfbp_pkg::S_DONE;
        end
      end

      cfbp_pkg::S_FREE_WR: begin
        cmd.addr    = hole_r;
        cmd.mem_we  = 1'b1;
        cmd.vld_we  = 1'b1;
        cmd.vld_val = 1'b1;
        free_nxt    = free_r + 1'b1;
        res_st_nxt  = cfbp_pkg::ST_OK;
        state_nxt   = cfbp_pkg::S_DONE;
      end

      // Hold the result until the output register is free
      cfbp_pkg::S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_st_nxt    = res_st_r;
          out_addr_nxt  = res_addr_r;
          out_free_nxt  = free_r;
          state_nxt     = cfbp_pkg::S_IDLE;
        end
      end

      default: state_nxt = cfbp_pkg::S_IDLE;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(cfbp_pkg::OUT_W - 42)'(0), out_free_r, out_addr_r, out_st_r};

`ifndef ASSERT_OFF
  a_free_le_active: assert property (@(posedge clk) disable iff (!rst_n)
    free_r <= active_r)
    else $error("free count above active block count");

  a_not_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !ready_r |-> (free_r == '0 && active_r == '0))
    else $error("pool not ready but counters nonzero");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r != cfbp_pkg::S_IDLE)
    else $error("accepted word did not start work");

  a_alloc_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == cfbp_pkg::S_ALLOC_RD |=> free_r + 1'b1 == $past(free_r))
    else $error("alloc did not take one block off the free count");
`endif

endmodule

[verif/checked_fixed_block_pool_unit_tb.sv]
// Self-checking bench for the checked fixed block pool: directed and random request words.
`timescale 1ns / 1ps

module checked_fixed_block_pool_unit_tb;

  // func value with no operation behind it
  localparam logic [1:0] FN_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]                  fn;
    logic [cfbp_pkg::ADDR_W-1:0] addr;
  } pool_word_t;

  typedef struct packed {
    cfbp_pkg::status_t           status;
    logic [cfbp_pkg::ADDR_W-1:0] blk;
    logic [cfbp_pkg::CNT_W-1:0]  free_n;
  } pool_result_t;

  logic                           clk        = 1'b0;
  logic                           rst_n      = 1'b0;
  logic                           in_tvalid  = 1'b0;
  logic                           in_tready;
  logic [cfbp_pkg::IN_W-1:0]      in_tdata   = '0;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [cfbp_pkg::OUT_W-1:0]     out_tdata;
  logic                           cfg_valid  = 1'b0;
  logic                           cfg_ready;
  logic [cfbp_pkg::CFG_IDX_W-1:0] cfg_index  = '0;
  logic [cfbp_pkg::ADDR_W-1:0]    cfg_data   = '0;

  // register copies and pool state as the block should hold them
  logic [cfbp_pkg::ADDR_W-1:0]  start_reg = '0;
  logic [cfbp_pkg::BYTES_W-1:0] bytes_reg = 16'd4;
  logic [cfbp_pkg::CNT_W-1:0]   count_reg = '0;
  logic [cfbp_pkg::ADDR_W-1:0]  slot_mirror [cfbp_pkg::NUM_SLOTS];
  int unsigned                  free_cnt    = 0;
  int unsigned                  active_cnt  = 0;
  bit                           pool_up     = 1'b0;
  logic [cfbp_pkg::ADDR_W-1:0]  pool_base   = '0;
  logic [cfbp_pkg::ADDR_W-1:0]  pool_last   = '0;
  int unsigned                  pool_stride = 0;

  pool_word_t   pool_requests [$];
  pool_result_t owed_replies  [$];
  int           bad_fields = 0;
  bit           word_held  = 1'b0;

  int           in_wait  = 0;
  int           in_calm  = 0;
  logic         in_next;
  pool_word_t   req_w;
  int           out_wait = 0;
  int           out_calm = 0;
  logic         out_next;
  pool_result_t want_r;

  checked_fixed_block_pool_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(string what, logic [cfbp_pkg::OUT_W-1:0] got,
                                 logic [cfbp_pkg::OUT_W-1:0] want);
    bad_fields++;
    if (bad_fields <= 100) begin
      $display("%0t: %s: got %0h, want %0h", $time, what, got, want);
    end
  endtask

  // Advance the pool by one request word and return the reply it owes.
  function automatic pool_result_t pool_apply(logic [1:0] fn, logic [cfbp_pkg::ADDR_W-1:0] a);
    pool_result_t                r;
    logic [cfbp_pkg::ADDR_W-1:0] got;
    longint unsigned             base, step, n, end_orig, end_al;
    bit                          done, have_hole;
    int                          hole;
    r.status  = cfbp_pkg::ST_PARAM;
    got       = '0;
    done      = 1'b0;
    have_hole = 1'b0;
    hole      = 0;
    case (fn)
      cfbp_pkg::FN_ALLOC: begin
        if (pool_up) begin
          r.status = cfbp_pkg::ST_EMPTY;
          if (free_cnt != 0) begin
            for (int i = 0; i < active_cnt; i++) begin
              if (!done && slot_mirror[i] != '0) begin
                got            = slot_mirror[i];
                slot_mirror[i] = '0;
                free_cnt--;
                r.status = cfbp_pkg::ST_OK;
                done     = 1'b1;
              end
            end
          end
        end
      end
      cfbp_pkg::FN_FREE: begin
        // zero is refused before readiness is looked at
        if (a == '0 || !pool_up) r.status = cfbp_pkg::ST_PARAM;
        else if (free_cnt >= active_cnt) r.status = cfbp_pkg::ST_FULL;
        else if (a < pool_base || a > pool_last) r.status = cfbp_pkg::ST_BADADDR;
        else begin
          r.status = cfbp_pkg::ST_OK;
          for (int i = 0; i < active_cnt; i++) begin
            if (!done) begin
              if (slot_mirror[i] == a) begin
                done     = 1'b1;
                r.status = cfbp_pkg::ST_DUP;
              end else if (!have_hole && slot_mirror[i] == '0) begin
                have_hole = 1'b1;
                hole      = i;
              end
            end
          end
          if (!done) begin
            if (!have_hole) r.status = cfbp_pkg::ST_NOSLOT;
            else begin
              slot_mirror[hole] = a;
              free_cnt++;
            end
          end
        end
      end
      cfbp_pkg::FN_INIT: begin
        if (pool_up) r.status = cfbp_pkg::ST_PARAM;
        else if (start_reg == '0 || count_reg < 2 || count_reg > cfbp_pkg::NUM_SLOTS
                 || bytes_reg < cfbp_pkg::MIN_BLOCK_BYTES) begin
          free_cnt   = 0;
          active_cnt = 0;
          pool_up    = 1'b0;
        end else begin
          for (int i = 0; i < count_reg; i++) slot_mirror[i] = '0;
          base     = (({32'b0, start_reg} + cfbp_pkg::ALIGN - 1) / cfbp_pkg::ALIGN)
                     * cfbp_pkg::ALIGN;
          step     = (({48'b0, bytes_reg} + cfbp_pkg::ALIGN - 1) / cfbp_pkg::ALIGN)
                     * cfbp_pkg::ALIGN;
          n        = count_reg;
          end_orig = {32'b0, start_reg} + {48'b0, bytes_reg} * n;
          end_al   = base + step * n;
          // drop blocks that run past the region end, then any that leave 32 bits
          while (n > 0 && end_al > end_orig) begin
            end_al -= step;
            n--;
          end
          while (n > 0 && base + step * (n - 1) > 64'hFFFF_FFFF) n--;
          if (n < 2) begin
            free_cnt   = 0;
            active_cnt = 0;
            pool_up    = 1'b0;
          end else begin
            for (int i = 0; i < n; i++) slot_mirror[i] = cfbp_pkg::ADDR_W'(base + step * i);
            pool_base   = cfbp_pkg::ADDR_W'(base);
            pool_last   = cfbp_pkg::ADDR_W'(base + step * (n - 1));
            pool_stride = int'(step);
            active_cnt  = int'(n);
            free_cnt    = int'(n);
            pool_up     = 1'b1;
            r.status    = cfbp_pkg::ST_OK;
          end
        end
      end
      default: r.status = cfbp_pkg::ST_PARAM;
    endcase
    r.blk    = (r.status == cfbp_pkg::ST_OK) ? got : '0;
    r.free_n = free_cnt[cfbp_pkg::CNT_W-1:0];
    return r;
  endfunction

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_wait   = 0;
      word_held = 1'b0;
    end else begin
      in_next = in_tvalid;
      if (in_tvalid && in_tready) begin
        owed_replies.push_back(pool_apply(in_tdata[1:0], in_tdata[cfbp_pkg::ADDR_W+1:2]));
        word_held = 1'b0;
        in_next   = 1'b0;
        if (in_calm > 0) begin
          in_calm--;
          in_wait = 0;
        end else begin
          in_wait = $urandom_range(0, 15);
          if ($urandom_range(0, 31) == 0) in_calm = $urandom_range(10, 60);
        end
      end
      if (!in_next) begin
        if (in_wait > 0) in_wait--;
        else if (pool_requests.size() != 0) begin
          req_w = pool_requests.pop_front();
          in_tdata  <= {{(cfbp_pkg::IN_W-cfbp_pkg::ADDR_W-2){1'b0}}, req_w.addr, req_w.fn};
          in_next   = 1'b1;
          word_held = 1'b1;
        end
      end
      in_tvalid <= in_next;
    end
  end

  // reply monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_wait   = 0;
    end else begin
      out_next = out_tready;
      if (out_tvalid && out_tready) begin
        if (owed_replies.size() == 0) begin
          report_mismatch("reply with nothing owed", out_tdata, '0);
        end else begin
          want_r = owed_replies.pop_front();
          if (out_tdata[2:0] !== want_r.status)
            report_mismatch("status", out_tdata[2:0], want_r.status);
          if (out_tdata[cfbp_pkg::ADDR_W+2:3] !== want_r.blk)
            report_mismatch("block_addr", out_tdata[cfbp_pkg::ADDR_W+2:3], want_r.blk);
          if (out_tdata[cfbp_pkg::ADDR_W+cfbp_pkg::CNT_W+2:cfbp_pkg::ADDR_W+3] !== want_r.free_n)
            report_mismatch("free_blocks",
                            out_tdata[cfbp_pkg::ADDR_W+cfbp_pkg::CNT_W+2:cfbp_pkg::ADDR_W+3],
                            want_r.free_n);
          if (out_tdata[cfbp_pkg::OUT_W-1:cfbp_pkg::ADDR_W+cfbp_pkg::CNT_W+3] !== '0)
            report_mismatch("pad bits",
                            out_tdata[cfbp_pkg::OUT_W-1:cfbp_pkg::ADDR_W+cfbp_pkg::CNT_W+3],
                            '0);
        end
        out_next = 1'b0;
        if (out_calm > 0) begin
          out_calm--;
          out_wait = 0;
        end else begin
          out_wait = $urandom_range(0, 15);
          if ($urandom_range(0, 31) == 0) out_calm = $urandom_range(10, 60);
        end
      end
      if (!out_next) begin
        if (out_wait > 0) out_wait--;
        else out_next = 1'b1;
      end
      out_tready <= out_next;
    end
  end

  task automatic send(logic [1:0] f, logic [cfbp_pkg::ADDR_W-1:0] a);
    pool_requests.push_back(pool_word_t'{fn: f, addr: a});
  endtask

  task automatic cfg_write(cfbp_pkg::cfg_idx_t idx, logic [cfbp_pkg::ADDR_W-1:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      cfbp_pkg::CFG_REGION_START: start_reg = v;
      cfbp_pkg::CFG_BLOCK_BYTES:  bytes_reg = v[cfbp_pkg::BYTES_W-1:0];
      cfbp_pkg::CFG_BLOCK_COUNT:  count_reg = v[cfbp_pkg::CNT_W-1:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  // Hold until every queued word is sent and answered, then let the block go idle.
  task automatic settle();
    while (pool_requests.size() != 0 || word_held || owed_replies.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    int alloc_pct;
    int pick;
    for (int i = 0; i < cfbp_pkg::NUM_SLOTS; i++) slot_mirror[i] = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // pool not ready yet; init from reset registers has region start zero
    send(cfbp_pkg::FN_ALLOC, 32'h0);
    send(cfbp_pkg::FN_FREE, 32'h0);
    send(cfbp_pkg::FN_FREE, 32'h0000_1000);
    send(FN_UNUSED, 32'hFFFF_FFFF);
    send(cfbp_pkg::FN_INIT, 32'h0);
    settle();

    // alignment trims every block away
    cfg_write(cfbp_pkg::CFG_REGION_START, 32'h0000_0001);
    cfg_write(cfbp_pkg::CFG_BLOCK_BYTES, 32'd5);
    cfg_write(cfbp_pkg::CFG_BLOCK_COUNT, 32'd2);
    send(cfbp_pkg::FN_INIT, 32'h0);
    settle();

    cfg_write(cfbp_pkg::CFG_BLOCK_COUNT, 32'd1);
    send(cfbp_pkg::FN_INIT, 32'h0);
    settle();

    cfg_write(cfbp_pkg::CFG_BLOCK_COUNT, 32'h7F);
    send(cfbp_pkg::FN_INIT, 32'h0);
    settle();

    cfg_write(cfbp_pkg::CFG_BLOCK_COUNT, 32'd64);
    cfg_write(cfbp_pkg::CFG_BLOCK_BYTES, 32'd3);
    send(cfbp_pkg::FN_INIT, 32'h0);
    settle();

    // aligned base already past 32 bits
    cfg_write(cfbp_pkg::CFG_REGION_START, 32'hFFFF_FFFF);
    cfg_write(cfbp_pkg::CFG_BLOCK_BYTES, 32'h0000_FFFF);
    send(cfbp_pkg::FN_INIT, 32'h0);
    settle();

    cfg_write(cfbp_pkg::CFG_BLOCK_BYTES, 32'h0);
    cfg_write(cfbp_pkg::CFG_BLOCK_COUNT, 32'h0);
    send(cfbp_pkg::FN_INIT, 32'h0);
    settle();

    // good pool near the top: end trim and wrap trim leave 62 blocks at 0xFFFFFF08
    cfg_write(cfbp_pkg::CFG_REGION_START, 32'hFFFF_FF05);
    cfg_write(cfbp_pkg::CFG_BLOCK_BYTES, 32'd4);
    cfg_write(cfbp_pkg::CFG_BLOCK_COUNT, 32'd64);
    send(cfbp_pkg::FN_INIT, 32'h0);
    send(cfbp_pkg::FN_INIT, 32'h0);
    send(cfbp_pkg::FN_FREE, 32'hFFFF_FF08);
    send(cfbp_pkg::FN_ALLOC, 32'h0);
    send(cfbp_pkg::FN_ALLOC, 32'hFFFF_FFFF);
    send(cfbp_pkg::FN_ALLOC, 32'h0);
    send(cfbp_pkg::FN_FREE, 32'hFFFF_FF0C);
    send(cfbp_pkg::FN_FREE, 32'hFFFF_FF0C);
    send(cfbp_pkg::FN_FREE, 32'hFFFF_FF04);
    send(cfbp_pkg::FN_FREE, 32'hFFFF_FFFD);
    send(cfbp_pkg::FN_FREE, 32'hFFFF_FF09);
    send(cfbp_pkg::FN_ALLOC, 32'h0);
    settle();

    // random traffic in runs that lean toward draining or refilling the pool
    for (int c = 0; c < 45; c++) begin
      case ($urandom_range(0, 2))
        0:       alloc_pct = 15;
        1:       alloc_pct = 50;
        default: alloc_pct = 85;
      endcase
      for (int k = 0; k < 40; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 2) send(cfbp_pkg::FN_INIT, $urandom());
        else if (pick < 4) send(FN_UNUSED, $urandom());
        else if (pick < 5) send(cfbp_pkg::FN_FREE, 32'h0);
        else if (pick < 8) send(cfbp_pkg::FN_FREE, $urandom());
        else if (pick < 11) send(cfbp_pkg::FN_FREE, $urandom_range(pool_last, pool_base));
        else if ($urandom_range(0, 99) < alloc_pct) send(cfbp_pkg::FN_ALLOC, $urandom());
        else send(cfbp_pkg::FN_FREE,
                  pool_base + pool_stride * $urandom_range(0, active_cnt - 1));
      end
    end
    settle();

    repeat (150) @(posedge clk);
    if (owed_replies.size() != 0)
      report_mismatch("replies never arrived", owed_replies.size(), '0);
    if (bad_fields == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
